@@ rtl/ppue_pkg.sv @@
// Shared types, constants and helper functions for the particle pool update engine.
`timescale 1ns / 1ps
`default_nettype none
package ppue_pkg;

    // Default sizing
    localparam int POOL_SIZE_DEF = 256;
    localparam int FRAC_BITS_DEF = 8;

    // Field widths
    localparam int WORD_W  = 24;
    localparam int COLOR_W = 8;
    localparam int OP_W    = 2;
    localparam int CODE_W  = 2;
    localparam int FPS_W   = 8;
    localparam int POS_W   = 11;
    localparam int VEL_W   = 7;
    localparam int SLOT_W  = 8;
    localparam int PIX_W   = 16;
    localparam int ALIVE_W = 9;
    localparam int WIND_W  = 11;
    localparam int GRAV_W  = 12;
    localparam int SCR_W   = 11;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 12;

    // Input word layout (tdata), lowest bit first
    localparam int S_TDATA_W  = 56;
    localparam int S_CODE_LSB = 0;
    localparam int S_FPS_LSB  = 2;
    localparam int S_SX_LSB   = 10;
    localparam int S_SY_LSB   = 21;
    localparam int S_VX_LSB   = 32;
    localparam int S_VY_LSB   = 39;
    localparam int S_SLOT_LSB = 46;

    // Output word layout (tdata), lowest bit first
    localparam int M_TDATA_W  = 64;
    localparam int M_SLOT_LSB = 0;
    localparam int M_ALIVE    = 8;
    localparam int M_ONSCR    = 9;
    localparam int M_PX_LSB   = 10;
    localparam int M_PY_LSB   = 26;
    localparam int M_COL_LSB  = 42;
    localparam int M_CNT_LSB  = 50;

    // Op codes (tuser)
    localparam logic [OP_W-1:0] OP_SPAWN = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Color codes
    localparam logic [CODE_W-1:0] CODE_RED   = 2'd0;
    localparam logic [CODE_W-1:0] CODE_GREEN = 2'd1;
    localparam logic [CODE_W-1:0] CODE_BLUE  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_WIND    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_GRAVITY = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_SCR_W   = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_SCR_H   = 2'd3;

    // Configuration reset values
    localparam logic [WIND_W-1:0] WIND_RST  = 11'd0;
    localparam logic [GRAV_W-1:0] GRAV_RST  = 12'd5;
    localparam logic [SCR_W-1:0]  SCR_W_RST = 11'd640;
    localparam logic [SCR_W-1:0]  SCR_H_RST = 11'd480;

    // Fade ranges
    localparam logic [COLOR_W-1:0] RED_FIRST   = 8'd32;
    localparam logic [COLOR_W-1:0] RED_END     = 8'd47;
    localparam logic [COLOR_W-1:0] GREEN_FIRST = 8'd96;
    localparam logic [COLOR_W-1:0] GREEN_END   = 8'd111;
    localparam logic [COLOR_W-1:0] BLUE_FIRST  = 8'd144;
    localparam logic [COLOR_W-1:0] BLUE_END    = 8'd159;
    localparam logic [COLOR_W-1:0] WHITE_FIRST = 8'd16;
    localparam logic [COLOR_W-1:0] WHITE_END   = 8'd31;

    // Saturation bounds of a position/velocity word
    localparam logic [WORD_W-1:0] WORD_MAX = 24'h7F_FFFF;
    localparam logic [WORD_W-1:0] WORD_MIN = 24'h80_0000;

    // One pool slot
    typedef struct packed {
        logic               alive;
        logic [WORD_W-1:0]  pos_x;
        logic [WORD_W-1:0]  pos_y;
        logic [WORD_W-1:0]  vel_x;
        logic [WORD_W-1:0]  vel_y;
        logic [COLOR_W-1:0] cur_col;
        logic [COLOR_W-1:0] end_col;
        logic [FPS_W-1:0]   frame_cnt;
        logic [FPS_W-1:0]   frame_lim;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch the input word, clear result staging
        logic rd_en;     // read one slot
        logic use_slot;  // read address from latched slot index
        logic clr_en;    // clear one slot (after reset)
        logic set_full;  // spawn found no free slot
        logic push;      // move staged result to the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic hit;       // spawn has placed its particle
        logic out_free;  // output register can take a result
    } t_stat;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPAWN,
        ST_SPAWN_DRAIN,
        ST_SPAWN_END,
        ST_TICK,
        ST_TICK_DRAIN,
        ST_READ,
        ST_READ_WAIT,
        ST_DONE
    } t_state;

    function automatic logic [COLOR_W-1:0] color_first(input logic [CODE_W-1:0] code);
        logic [COLOR_W-1:0] c;
        case (code)
            CODE_RED:   c = RED_FIRST;
            CODE_GREEN: c = GREEN_FIRST;
            CODE_BLUE:  c = BLUE_FIRST;
            default:    c = WHITE_FIRST;
        endcase
        return c;
    endfunction

    function automatic logic [COLOR_W-1:0] color_end(input logic [CODE_W-1:0] code);
        logic [COLOR_W-1:0] c;
        case (code)
            CODE_RED:   c = RED_END;
            CODE_GREEN: c = GREEN_END;
            CODE_BLUE:  c = BLUE_END;
            default:    c = WHITE_END;
        endcase
        return c;
    endfunction

    // Signed add with clamp to the word range
    function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        logic [WORD_W-1:0] r;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1]) begin
            r = s[WORD_W] ? WORD_MIN : WORD_MAX;
        end else begin
            r = s[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/ppue_ctrl.sv @@
// Controller: sequences clearing, spawn scan, tick sweep, slot read and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module ppue_ctrl #(
    parameter int POOL_SIZE = ppue_pkg::POOL_SIZE_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_tvalid,
    output logic                           o_s_tready,
    input  wire logic [ppue_pkg::OP_W-1:0] i_op,
    output ppue_pkg::t_cmd                 o_cmd,
    output logic [$clog2(POOL_SIZE)-1:0]   o_addr,
    input  wire ppue_pkg::t_stat           i_stat
);

    localparam int AW = $clog2(POOL_SIZE);
    localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_SIZE - 1);

    ppue_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_cnt, n_cnt;
    logic             w_accept;

    assign w_accept = i_s_tvalid && o_s_tready;

    // State and slot counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppue_pkg::ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ppue_pkg::ST_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_SLOT) begin
                    n_cnt   = '0;
                    n_state = ppue_pkg::ST_IDLE;
                end
            end
            ppue_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_cnt = '0;
                    case (i_op)
                        ppue_pkg::OP_SPAWN: n_state = ppue_pkg::ST_SPAWN;
                        ppue_pkg::OP_TICK:  n_state = ppue_pkg::ST_TICK;
                        ppue_pkg::OP_READ:  n_state = ppue_pkg::ST_READ;
                        default:            n_state = ppue_pkg::ST_DONE;
                    endcase
                end
            end
            ppue_pkg::ST_SPAWN: begin
                if (i_stat.hit) begin
                    n_state = ppue_pkg::ST_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == LAST_SLOT) begin
                        n_state = ppue_pkg::ST_SPAWN_DRAIN;
                    end
                end
            end
            ppue_pkg::ST_SPAWN_DRAIN: n_state = ppue_pkg::ST_SPAWN_END;
            ppue_pkg::ST_SPAWN_END:   n_state = ppue_pkg::ST_DONE;
            ppue_pkg::ST_TICK: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_SLOT) begin
                    n_state = ppue_pkg::ST_TICK_DRAIN;
                end
            end
            ppue_pkg::ST_TICK_DRAIN: n_state = ppue_pkg::ST_DONE;
            ppue_pkg::ST_READ:       n_state = ppue_pkg::ST_READ_WAIT;
            ppue_pkg::ST_READ_WAIT:  n_state = ppue_pkg::ST_DONE;
            ppue_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = ppue_pkg::ST_IDLE;
                end
            end
            default: n_state = ppue_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_addr     = r_cnt;
        o_s_tready = 1'b0;
        case (r_state)
            ppue_pkg::ST_CLEAR: o_cmd.clr_en = 1'b1;
            ppue_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = w_accept;
            end
            ppue_pkg::ST_SPAWN:     o_cmd.rd_en = !i_stat.hit;
            ppue_pkg::ST_SPAWN_END: o_cmd.set_full = !i_stat.hit;
            ppue_pkg::ST_TICK:      o_cmd.rd_en = 1'b1;
            ppue_pkg::ST_READ: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.use_slot = 1'b1;
            end
            ppue_pkg::ST_DONE:      o_cmd.push = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/ppue_dp.sv @@
// Datapath: slot memory, config registers, particle update, spawn fill, read decode, output.
`timescale 1ns / 1ps
`default_nettype none
module ppue_dp #(
    parameter int POOL_SIZE = ppue_pkg::POOL_SIZE_DEF,
    parameter int FRAC_BITS = ppue_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ppue_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  wire logic [ppue_pkg::CFG_DW-1:0]    i_cfg_wdata,
    input  wire logic [ppue_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  wire logic [ppue_pkg::OP_W-1:0]      i_s_tuser,
    input  wire ppue_pkg::t_cmd                 i_cmd,
    input  wire logic [$clog2(POOL_SIZE)-1:0]   i_addr,
    output ppue_pkg::t_stat                     o_stat,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [ppue_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic                                o_m_tuser
);

    localparam int AW  = $clog2(POOL_SIZE);
    localparam int LW  = $clog2(POOL_SIZE + 1);
    localparam int WW  = ppue_pkg::WORD_W;
    localparam int CW  = ppue_pkg::ALIVE_W;
    localparam int SW  = ppue_pkg::SLOT_W;
    localparam int PW  = ppue_pkg::PIX_W;
    localparam int FW  = ppue_pkg::FPS_W;
    localparam int KW  = ppue_pkg::COLOR_W;
    localparam int PSW = ppue_pkg::POS_W;
    localparam int VSW = ppue_pkg::VEL_W;

    // Config registers
    logic [ppue_pkg::WIND_W-1:0] r_wind;
    logic [ppue_pkg::GRAV_W-1:0] r_grav;
    logic [ppue_pkg::SCR_W-1:0]  r_scr_w;
    logic [ppue_pkg::SCR_W-1:0]  r_scr_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wind  <= ppue_pkg::WIND_RST;
            r_grav  <= ppue_pkg::GRAV_RST;
            r_scr_w <= ppue_pkg::SCR_W_RST;
            r_scr_h <= ppue_pkg::SCR_H_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ppue_pkg::CFG_WIND:    r_wind  <= i_cfg_wdata[ppue_pkg::WIND_W-1:0];
                ppue_pkg::CFG_GRAVITY: r_grav  <= i_cfg_wdata[ppue_pkg::GRAV_W-1:0];
                ppue_pkg::CFG_SCR_W:   r_scr_w <= i_cfg_wdata[ppue_pkg::SCR_W-1:0];
                ppue_pkg::CFG_SCR_H:   r_scr_h <= i_cfg_wdata[ppue_pkg::SCR_W-1:0];
                default: r_wind <= r_wind;
            endcase
        end
    end

    // Latched input word
    logic [ppue_pkg::OP_W-1:0]   r_op;
    logic [ppue_pkg::CODE_W-1:0] r_code;
    logic [FW-1:0]               r_fps;
    logic [PSW-1:0]              r_sx, r_sy;
    logic [VSW-1:0]              r_svx, r_svy;
    logic [SW-1:0]               r_slot_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_s_tuser;
            r_code     <= i_s_tdata[ppue_pkg::S_CODE_LSB +: ppue_pkg::CODE_W];
            r_fps      <= i_s_tdata[ppue_pkg::S_FPS_LSB +: FW];
            r_sx       <= i_s_tdata[ppue_pkg::S_SX_LSB +: PSW];
            r_sy       <= i_s_tdata[ppue_pkg::S_SY_LSB +: PSW];
            r_svx      <= i_s_tdata[ppue_pkg::S_VX_LSB +: VSW];
            r_svy      <= i_s_tdata[ppue_pkg::S_VY_LSB +: VSW];
            r_slot_idx <= i_s_tdata[ppue_pkg::S_SLOT_LSB +: SW];
        end
    end

    // Slot memory, one write and one registered read per cycle
    ppue_pkg::t_entry r_mem [POOL_SIZE];
    ppue_pkg::t_entry r_q;
    ppue_pkg::t_entry w_wd;
    logic [AW-1:0]    w_ra, w_wa;
    logic             w_we;

    assign w_ra = i_cmd.use_slot ? AW'(r_slot_idx) : i_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_q <= r_mem[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
    end

    // Read stage tracking
    logic          r_st_vld;
    logic [AW-1:0] r_st_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_vld <= 1'b0;
        end else begin
            r_st_vld <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_st_addr <= w_ra;
        end
    end

    // Spawn: first dead slot seen by the scan
    logic r_hit;
    logic w_spawn_hit;
    ppue_pkg::t_entry w_new;

    assign w_spawn_hit = r_st_vld && (r_op == ppue_pkg::OP_SPAWN) && !r_q.alive && !r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.load) begin
            r_hit <= 1'b0;
        end else if (w_spawn_hit) begin
            r_hit <= 1'b1;
        end
    end

    always_comb begin
        w_new.alive     = 1'b1;
        w_new.pos_x     = {{(WW-PSW){r_sx[PSW-1]}}, r_sx} << FRAC_BITS;
        w_new.pos_y     = {{(WW-PSW){r_sy[PSW-1]}}, r_sy} << FRAC_BITS;
        w_new.vel_x     = {{(WW-VSW){r_svx[VSW-1]}}, r_svx} << FRAC_BITS;
        w_new.vel_y     = {{(WW-VSW){r_svy[VSW-1]}}, r_svy} << FRAC_BITS;
        w_new.cur_col   = ppue_pkg::color_first(r_code);
        w_new.end_col   = ppue_pkg::color_end(r_code);
        w_new.frame_cnt = '0;
        w_new.frame_lim = r_fps;
    end

    // Tick: motion, acceleration and fade of one slot
    ppue_pkg::t_entry w_upd;
    logic             w_tick_wb, w_dies;
    logic [FW:0]      w_cnt;
    logic [KW:0]      w_nc;
    logic [WW-1:0]    w_wind_x, w_grav_x;

    assign w_tick_wb = r_st_vld && (r_op == ppue_pkg::OP_TICK) && r_q.alive;
    assign w_wind_x  = {{(WW-ppue_pkg::WIND_W){r_wind[ppue_pkg::WIND_W-1]}}, r_wind};
    assign w_grav_x  = {{(WW-ppue_pkg::GRAV_W){r_grav[ppue_pkg::GRAV_W-1]}}, r_grav};
    assign w_cnt     = {1'b0, r_q.frame_cnt} + 1'b1;
    assign w_nc      = {1'b0, r_q.cur_col} + 1'b1;

    always_comb begin
        w_upd       = r_q;
        w_dies      = 1'b0;
        w_upd.pos_x = ppue_pkg::sat_add(r_q.pos_x, r_q.vel_x);
        w_upd.pos_y = ppue_pkg::sat_add(r_q.pos_y, r_q.vel_y);
        w_upd.vel_x = ppue_pkg::sat_add(r_q.vel_x, w_wind_x);
        w_upd.vel_y = ppue_pkg::sat_add(r_q.vel_y, w_grav_x);
        if (w_cnt >= {1'b0, r_q.frame_lim}) begin
            w_upd.frame_cnt = '0;
            w_upd.cur_col   = w_nc[KW-1:0];
            if (w_nc > {1'b0, r_q.end_col}) begin
                w_upd.alive = 1'b0;
                w_dies      = 1'b1;
            end
        end else begin
            w_upd.frame_cnt = w_cnt[FW-1:0];
        end
    end

    // Write port select
    always_comb begin
        w_we = 1'b0;
        w_wa = r_st_addr;
        w_wd = w_upd;
        if (i_cmd.clr_en) begin
            w_we = 1'b1;
            w_wa = i_addr;
            w_wd = '0;
        end else if (w_spawn_hit) begin
            w_we = 1'b1;
            w_wd = w_new;
        end else if (w_tick_wb) begin
            w_we = 1'b1;
        end
    end

    // Live particle count
    logic [LW-1:0] r_live;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
        end else if (w_spawn_hit) begin
            r_live <= r_live + 1'b1;
        end else if (w_tick_wb && w_dies && (r_live != '0)) begin
            r_live <= r_live - 1'b1;
        end
    end

    // Read decode: floor to pixels and screen test
    logic [WW-1:0] w_shx, w_shy;
    logic          w_in_range, w_rd_alive, w_onscr;

    assign w_shx      = $signed(r_q.pos_x) >>> FRAC_BITS;
    assign w_shy      = $signed(r_q.pos_y) >>> FRAC_BITS;
    assign w_in_range = 32'(r_slot_idx) < POOL_SIZE;
    assign w_rd_alive = w_in_range && r_q.alive;
    assign w_onscr    = !w_shx[WW-1] && (w_shx < {{(WW-ppue_pkg::SCR_W){1'b0}}, r_scr_w}) &&
                        !w_shy[WW-1] && (w_shy < {{(WW-ppue_pkg::SCR_W){1'b0}}, r_scr_h});

    // Result staging
    logic          r_res_status, r_res_alive, r_res_onscr;
    logic [SW-1:0] r_res_slot;
    logic [PW-1:0] r_res_px, r_res_py;
    logic [KW-1:0] r_res_col;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res_status <= 1'b0;
            r_res_alive  <= 1'b0;
            r_res_onscr  <= 1'b0;
            r_res_slot   <= '0;
            r_res_px     <= '0;
            r_res_py     <= '0;
            r_res_col    <= '0;
        end else begin
            if (i_cmd.set_full) begin
                r_res_status <= 1'b1;
            end
            if (w_spawn_hit) begin
                r_res_slot <= SW'(r_st_addr);
            end
            if (r_st_vld && (r_op == ppue_pkg::OP_READ)) begin
                r_res_slot  <= r_slot_idx;
                r_res_alive <= w_rd_alive;
                r_res_onscr <= w_rd_alive && w_onscr;
                r_res_px    <= w_rd_alive ? w_shx[PW-1:0] : '0;
                r_res_py    <= w_rd_alive ? w_shy[PW-1:0] : '0;
                r_res_col   <= w_rd_alive ? r_q.cur_col : '0;
            end
        end
    end

    // Result word packing
    logic [ppue_pkg::M_TDATA_W-1:0] w_m_word;

    always_comb begin
        w_m_word = '0;
        w_m_word[ppue_pkg::M_SLOT_LSB +: SW] = r_res_slot;
        w_m_word[ppue_pkg::M_ALIVE]          = r_res_alive;
        w_m_word[ppue_pkg::M_ONSCR]          = r_res_onscr;
        w_m_word[ppue_pkg::M_PX_LSB +: PW]   = r_res_px;
        w_m_word[ppue_pkg::M_PY_LSB +: PW]   = r_res_py;
        w_m_word[ppue_pkg::M_COL_LSB +: KW]  = r_res_col;
        w_m_word[ppue_pkg::M_CNT_LSB +: CW]  = CW'(r_live);
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (i_cmd.push) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            o_m_tuser <= r_res_status;
            o_m_tdata <= w_m_word;
        end
    end

    assign o_stat.hit      = r_hit;
    assign o_stat.out_free = !o_m_tvalid || i_m_tready;

endmodule
`default_nettype wire

@@ rtl/particle_pool_update_engine_top.sv @@
// Top level of the particle pool update engine: controller plus datapath.
// Each accepted word runs one op: read decodes one slot, spawn scans for the first free
// slot or, when the pool is full, the whole pool; tick sweeps the pool, one slot per cycle.
// Throughput: one word at a time, next word taken the cycle after the result is pushed;
// a held result stalls o_s_tready.
// Reset: sync active low, then a clearing pass over every slot with o_s_tready low.
`timescale 1ns / 1ps
`default_nettype none
module particle_pool_update_engine_top #(
    parameter int POOL_SIZE = ppue_pkg::POOL_SIZE_DEF,
    parameter int FRAC_BITS = ppue_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // config port
    input  wire logic                           i_cfg_we,
    input  wire logic [ppue_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  wire logic [ppue_pkg::CFG_DW-1:0]    i_cfg_wdata,
    // input stream
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // color_code[1:0], frames_per_step[9:2], start_x[20:10], start_y[31:21],
    // start_vx[38:32], start_vy[45:39], slot_index[53:46], zero pad [55:54]
    input  wire logic [ppue_pkg::S_TDATA_W-1:0] i_s_tdata,
    // op[1:0]
    input  wire logic [ppue_pkg::OP_W-1:0]      i_s_tuser,
    // output stream
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // slot[7:0], is_alive[8], on_screen[9], pixel_x[25:10], pixel_y[41:26],
    // color_index[49:42], alive_count[58:50], zero pad [63:59]
    output logic [ppue_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // status[0]
    output logic                                o_m_tuser
);

    ppue_pkg::t_cmd                 w_cmd;
    ppue_pkg::t_stat                w_stat;
    logic [$clog2(POOL_SIZE)-1:0]   w_addr;

    ppue_ctrl #(
        .POOL_SIZE (POOL_SIZE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_op       (i_s_tuser),
        .o_cmd      (w_cmd),
        .o_addr     (w_addr),
        .i_stat     (w_stat)
    );

    ppue_dp #(
        .POOL_SIZE (POOL_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cmd       (w_cmd),
        .i_addr      (w_addr),
        .o_stat      (w_stat),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule
`default_nettype wire

@@ rtl/ppue_checker.sv @@
// Port-level checks for the particle pool update engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ppue_checker #(
    parameter int POOL_SIZE = ppue_pkg::POOL_SIZE_DEF
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic [ppue_pkg::M_TDATA_W-1:0] o_m_tdata,
    input wire logic                           o_m_tuser
);

    localparam int CW = ppue_pkg::ALIVE_W;

    logic          w_alive, w_onscr;
    logic [CW-1:0] w_count;

    assign w_alive = o_m_tdata[ppue_pkg::M_ALIVE];
    assign w_onscr = o_m_tdata[ppue_pkg::M_ONSCR];
    assign w_count = o_m_tdata[ppue_pkg::M_CNT_LSB +: CW];

    // A stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result word changed while stalled");

    // A dropped spawn only happens with every slot alive
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> w_count == CW'(POOL_SIZE))
        else $error("spawn dropped with free slots");

    // On screen implies alive
    a_onscr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_onscr |-> w_alive)
        else $error("on_screen set for a dead slot");

    // Dead report carries zero pixel and color fields
    a_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !w_alive |->
            o_m_tdata[ppue_pkg::M_TDATA_W-1:ppue_pkg::M_PX_LSB] ==
            {{(ppue_pkg::M_TDATA_W - ppue_pkg::M_CNT_LSB - CW){1'b0}}, w_count,
             {(ppue_pkg::M_CNT_LSB - ppue_pkg::M_PX_LSB){1'b0}}})
        else $error("dead slot reported with nonzero fields");

    // Live count stays within the pool
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (POOL_SIZE > 511) || (32'(w_count) <= POOL_SIZE))
        else $error("alive count beyond pool size");

endmodule

bind particle_pool_update_engine_top ppue_checker #(
    .POOL_SIZE (POOL_SIZE)
) u_ppue_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
